@@ src/afrc_pkg.sv @@
// Package: byte codes, phase, event, reply and fault codes for the frame checker.
`default_nettype none
package afrc_pkg;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_ETB = 8'h17;

  localparam logic [15:0] MAX_FRAME_RESET = 16'd1024;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BODY  = 2'd1,
    PH_CHECK = 2'd2,
    PH_TAIL  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_ENQ        = 3'd0,
    EV_EOT        = 3'd1,
    EV_ACK_SEEN   = 3'd2,
    EV_NAK_SEEN   = 3'd3,
    EV_FRAME_GOOD = 3'd4,
    EV_FRAME_BAD  = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    RP_NONE = 2'd0,
    RP_ACK  = 2'd1,
    RP_NAK  = 2'd2
  } reply_t;

  typedef enum logic [2:0] {
    FC_NONE     = 3'd0,
    FC_MISMATCH = 3'd1,
    FC_BAD_HEX  = 3'd2,
    FC_JUNK     = 3'd3,
    FC_OVERFLOW = 3'd4
  } fault_t;

endpackage : afrc_pkg
`default_nettype wire

@@ src/afrc_if.sv @@
// Interfaces: received byte channel and event result channel.
`default_nettype none
interface afrc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface : afrc_rx_if

interface afrc_ev_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [1:0]  reply_code;
  logic [7:0]  sum_computed;
  logic [7:0]  sum_received;
  logic [15:0] frame_bytes;
  logic [2:0]  fault_cause;

  modport source (output valid, output event_kind, output reply_code, output sum_computed,
                  output sum_received, output frame_bytes, output fault_cause,
                  input ready);
  modport sink   (input valid, input event_kind, input reply_code, input sum_computed,
                  input sum_received, input frame_bytes, input fault_cause,
                  output ready);
endinterface : afrc_ev_if
`default_nettype wire

@@ src/astm_frame_receiver_checker_unit.sv @@
// Top level: frame receiver with modulo-256 checksum check and control byte events.
//
//   channel   dir  handshake      payload
//   rx        in   valid/ready    rx_byte[7:0]
//   ev        out  valid/ready    event_kind, reply_code, sums, frame_bytes, fault_cause
//   cfg       in   cfg_wr_en      cfg_wr_data[15:0] -> max_frame_bytes
//
// One byte per cycle; the frame state and any event are registered at the accepting
// edge, so the event is offered on ev from the next cycle. The single output register
// stalls rx only while an event is held and ev.ready is low. Synchronous reset returns
// to idle, limit 1024.
`default_nettype none
module astm_frame_receiver_checker_unit
  import afrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  afrc_rx_if.sink          rx,
  afrc_ev_if.source        ev,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic [15:0] max_frame_bytes;
  phase_t      phase, phase_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  check_value, check_value_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] byte_count, byte_count_next;
  fault_t      fault_seen, fault_seen_next;

  logic        out_valid;
  event_t      out_kind;
  reply_t      out_reply;
  logic [7:0]  out_sc, out_sr;
  logic [15:0] out_nb;
  fault_t      out_fc;

  logic        acc, emit;
  event_t      res_kind;
  reply_t      res_reply;
  fault_t      res_fc;
  logic [7:0]  c;
  logic        is_ctrl, is_lf, at_lim, hex_ok;
  logic [15:0] cnt_inc;
  fault_t      fault_cnt;
  logic [3:0]  nib;
  logic [1:0]  hex_inc;

  assign rx.ready = !out_valid || ev.ready;
  assign acc      = rx.valid && rx.ready;
  assign c        = rx.rx_byte;
  assign is_ctrl  = (c == CH_ENQ) || (c == CH_EOT) || (c == CH_ACK) || (c == CH_NAK);
  assign is_lf    = (c == CH_LF);

  // byte counter saturates at the limit and flags overflow once
  assign at_lim    = (byte_count >= max_frame_bytes);
  assign cnt_inc   = at_lim ? max_frame_bytes : byte_count + 16'd1;
  assign fault_cnt = (fault_seen == FC_NONE && at_lim) ? FC_OVERFLOW : fault_seen;
  assign hex_inc   = hex_count + 2'd1;

  always_comb begin
    hex_ok = 1'b1;
    nib    = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      nib = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      nib = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (!is_ctrl && c == CH_STX) phase_next = PH_BODY;
      end
      PH_BODY: begin
        if (c == CH_ETX || c == CH_ETB) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        if (is_lf) phase_next = PH_IDLE;
        else if (hex_inc >= 2'd2) phase_next = PH_TAIL;
      end
      PH_TAIL: begin
        if (is_lf) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    running_sum_next = running_sum;
    check_value_next = check_value;
    hex_count_next   = hex_count;
    byte_count_next  = cnt_inc;
    fault_seen_next  = fault_cnt;
    emit             = 1'b0;
    res_kind         = EV_ENQ;
    res_reply        = RP_NONE;
    res_fc           = FC_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (is_ctrl) begin
          emit             = 1'b1;
          running_sum_next = 8'd0;
          check_value_next = 8'd0;
          hex_count_next   = 2'd0;
          byte_count_next  = 16'd0;
          fault_seen_next  = FC_NONE;
          unique case (c)
            CH_ENQ: begin
              res_kind  = EV_ENQ;
              res_reply = RP_ACK;
            end
            CH_EOT:  res_kind = EV_EOT;
            CH_ACK:  res_kind = EV_ACK_SEEN;
            default: res_kind = EV_NAK_SEEN;
          endcase
        end else if (c == CH_STX) begin
          running_sum_next = 8'd0;
        end else if (fault_cnt == FC_NONE) begin
          fault_seen_next = FC_JUNK;
        end
      end
      PH_BODY: begin
        running_sum_next = running_sum + c;
        if (c == CH_ETX || c == CH_ETB) begin
          hex_count_next   = 2'd0;
          check_value_next = 8'd0;
        end
      end
      PH_CHECK, PH_TAIL: begin
        if (!is_lf) begin
          if (phase == PH_CHECK) begin
            if (!hex_ok && fault_cnt == FC_NONE) fault_seen_next = FC_BAD_HEX;
            check_value_next = {check_value[3:0], nib};
            hex_count_next   = hex_inc;
          end
        end else begin
          // LF closes the frame; an LF among the digits counts as a bad digit
          emit   = 1'b1;
          res_fc = fault_cnt;
          if (phase == PH_CHECK && res_fc == FC_NONE) res_fc = FC_BAD_HEX;
          if (res_fc == FC_NONE && check_value != running_sum) res_fc = FC_MISMATCH;
          res_kind         = (res_fc == FC_NONE) ? EV_FRAME_GOOD : EV_FRAME_BAD;
          res_reply        = (res_fc == FC_NONE) ? RP_ACK : RP_NAK;
          running_sum_next = 8'd0;
          check_value_next = 8'd0;
          hex_count_next   = 2'd0;
          byte_count_next  = 16'd0;
          fault_seen_next  = FC_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
      phase           <= PH_IDLE;
      running_sum     <= 8'd0;
      check_value     <= 8'd0;
      hex_count       <= 2'd0;
      byte_count      <= 16'd0;
      fault_seen      <= FC_NONE;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) max_frame_bytes <= cfg_wr_data;
      if (acc) begin
        phase       <= phase_next;
        running_sum <= running_sum_next;
        check_value <= check_value_next;
        hex_count   <= hex_count_next;
        byte_count  <= byte_count_next;
        fault_seen  <= fault_seen_next;
      end
      if (acc && emit) out_valid <= 1'b1;
      else if (ev.ready) out_valid <= 1'b0;
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (acc && emit) begin
      out_kind  <= res_kind;
      out_reply <= res_reply;
      out_fc    <= res_fc;
      out_sc    <= (res_kind == EV_FRAME_GOOD || res_kind == EV_FRAME_BAD) ? running_sum : 8'd0;
      out_sr    <= (res_kind == EV_FRAME_GOOD || res_kind == EV_FRAME_BAD) ? check_value : 8'd0;
      out_nb    <= (res_kind == EV_FRAME_GOOD || res_kind == EV_FRAME_BAD) ? cnt_inc : 16'd0;
    end
  end

  assign ev.valid        = out_valid;
  assign ev.event_kind   = out_kind;
  assign ev.reply_code   = out_reply;
  assign ev.sum_computed = out_sc;
  assign ev.sum_received = out_sr;
  assign ev.frame_bytes  = out_nb;
  assign ev.fault_cause  = out_fc;

  a_no_stored_mismatch: assert property (@(posedge clk) disable iff (rst)
    fault_seen != FC_MISMATCH)
    else $error("mismatch held as a recorded fault");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> (running_sum == 8'd0 && check_value == 8'd0 && hex_count == 2'd0))
    else $error("idle with frame sums not cleared");

  a_good_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == EV_FRAME_GOOD) |->
      (out_fc == FC_NONE && out_sc == out_sr && out_reply == RP_ACK))
    else $error("good frame event with fault or unequal sums");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ev.ready) |=> (out_valid && $stable(out_kind) && $stable(out_nb)))
    else $error("held event overwritten");

endmodule : astm_frame_receiver_checker_unit
`default_nettype wire
